FILE: hdl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the condition a holds, the consequence c must hold in the same cycle.
`define CHK_SAME(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// The condition a must never hold.
`define CHK_NEVER(lbl, clk, rst_n, a, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(a)) else $error(msg);

`endif

FILE: hdl/stp_pkg.sv
package stp_pkg;

    localparam int TABLES      = 8;
    localparam int POINTS      = 16;
    localparam int TICK_BITS   = 16;
    localparam int ACTION_BITS = 16;
    localparam int MAX_RES     = 8;
    localparam int QDEPTH      = 4;

    localparam int TBL_W   = $clog2(TABLES);
    localparam int PT_W    = $clog2(POINTS);
    localparam int CNT_W   = $clog2(POINTS + 1);
    localparam int ADDR_W  = TBL_W + PT_W;
    localparam int MEM_D   = TABLES * POINTS;
    localparam int DIV_W   = TICK_BITS + 2;
    localparam int RES_W   = $clog2(MAX_RES + 1);

    typedef enum logic [2:0] {
        RQ_TICK      = 3'd0,
        RQ_START_REL = 3'd1,
        RQ_START_ABS = 3'd2,
        RQ_STOP      = 3'd3,
        RQ_CHAIN     = 3'd4,
        RQ_LOAD_PT   = 3'd5,
        RQ_LOAD_TBL  = 3'd6,
        RQ_UNKNOWN   = 3'd7
    } t_req_kind;

    typedef enum logic [2:0] {
        SC_OK          = 3'd0,
        SC_BAD_ID      = 3'd1,
        SC_BAD_VALUE   = 3'd2,
        SC_WRONG_STATE = 3'd3,
        SC_NO_FUNC     = 3'd4
    } t_code;

    typedef enum logic [1:0] {
        ST_STOP = 2'd0,
        ST_NEXT = 2'd1,
        ST_RUN  = 2'd2
    } t_run;

    localparam logic RK_STATUS = 1'b0;
    localparam logic RK_FIRED  = 1'b1;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_REQ_RD,
        BK_REQ_EX,
        BK_TICK,
        BK_SCAN,
        BK_APPLY,
        BK_MOD,
        BK_FIN
    } t_bk_state;

    typedef struct packed {
        t_req_kind              kind;
        logic                   bad_id;
        logic                   bad_val;
        logic [2:0]             tid;
        logic [2:0]             oid;
        logic [TICK_BITS-1:0]   val;
        logic [3:0]             pidx;
        logic [ACTION_BITS-1:0] pact;
        logic [4:0]             ptot;
        logic                   rep;
    } t_req;

    // A point count of zero behaves as one; counts are capped at the slot count.
    function automatic logic [CNT_W-1:0] eff_points(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] r;
        r = n;
        if (n == '0) r = CNT_W'(1);
        else if (n > CNT_W'(POINTS)) r = CNT_W'(POINTS);
        return r;
    endfunction

endpackage

FILE: hdl/stp_front.sv
module stp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2:0]                    i_req_type,
    input  logic [2:0]                    i_table_id,
    input  logic [2:0]                    i_other_table_id,
    input  logic [stp_pkg::TICK_BITS-1:0] i_value,
    input  logic [3:0]                    i_point_index,
    input  logic [stp_pkg::ACTION_BITS-1:0] i_point_action,
    input  logic [4:0]                    i_point_total,
    input  logic                          i_repeat_mode,
    output logic                          o_req_valid,
    input  logic                          i_req_pop,
    output stp_pkg::t_req                 o_req
);

    localparam int QP_W = $clog2(stp_pkg::QDEPTH);
    localparam int QC_W = $clog2(stp_pkg::QDEPTH + 1);

    stp_pkg::t_req    r_q [stp_pkg::QDEPTH];
    logic [QP_W-1:0]  r_wp, r_rp;
    logic [QC_W-1:0]  r_cnt;
    stp_pkg::t_req    cls;
    logic             push;

    // Classify the incoming request so the back end only sees decoded flags.
    always_comb begin
        cls.kind    = stp_pkg::t_req_kind'(i_req_type);
        cls.tid     = i_table_id;
        cls.oid     = i_other_table_id;
        cls.val     = i_value;
        cls.pidx    = i_point_index;
        cls.pact    = i_point_action;
        cls.ptot    = i_point_total;
        cls.rep     = i_repeat_mode;
        cls.bad_id  = 1'b0;
        cls.bad_val = 1'b0;
        if (cls.kind != stp_pkg::RQ_TICK && cls.kind != stp_pkg::RQ_UNKNOWN) begin
            cls.bad_id = ({1'b0, i_table_id} >= 4'(stp_pkg::TABLES)) ||
                         (cls.kind == stp_pkg::RQ_CHAIN &&
                          {1'b0, i_other_table_id} >= 4'(stp_pkg::TABLES));
        end
        if (cls.kind == stp_pkg::RQ_LOAD_PT) begin
            cls.bad_val = {1'b0, i_point_index} >= 5'(stp_pkg::POINTS);
        end else if (cls.kind == stp_pkg::RQ_LOAD_TBL) begin
            cls.bad_val = (i_point_total == 5'd0) ||
                          ({1'b0, i_point_total} > 6'(stp_pkg::POINTS));
        end
    end

    assign o_stall     = (r_cnt == QC_W'(stp_pkg::QDEPTH));
    assign push        = i_valid && !o_stall;
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + QP_W'(1);
            if (i_req_pop) r_rp <= r_rp + QP_W'(1);
            if (push && !i_req_pop) r_cnt <= r_cnt + QC_W'(1);
            else if (!push && i_req_pop) r_cnt <= r_cnt - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cls;
    end

endmodule

FILE: hdl/stp_mod.sv
module stp_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [stp_pkg::DIV_W-1:0]   i_dividend,
    input  logic [stp_pkg::TICK_BITS:0] i_modulus,
    output logic                        o_done,
    output logic [stp_pkg::TICK_BITS:0] o_rem
);

    localparam int SC_W = $clog2(stp_pkg::DIV_W + 1);

    logic                        r_busy, r_done;
    logic [SC_W-1:0]             r_cnt;
    logic [stp_pkg::DIV_W-1:0]   r_div;
    logic [stp_pkg::TICK_BITS:0] r_m, r_rem;
    logic [stp_pkg::TICK_BITS+1:0] trial;
    logic [stp_pkg::TICK_BITS+1:0] diff;

    // Restoring remainder, one dividend bit per cycle.
    assign trial  = {r_rem, r_div[stp_pkg::DIV_W-1]};
    assign diff   = trial - {1'b0, r_m};
    assign o_done = r_done;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SC_W'(stp_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - SC_W'(1);
                if (r_cnt == SC_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_dividend;
            r_m   <= i_modulus;
            r_rem <= '0;
        end else if (r_busy) begin
            r_div <= r_div << 1;
            if (trial >= {1'b0, r_m}) r_rem <= diff[stp_pkg::TICK_BITS:0];
            else r_rem <= trial[stp_pkg::TICK_BITS:0];
        end
    end

endmodule

FILE: hdl/stp_back.sv
module stp_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_pop,
    input  stp_pkg::t_req                   i_req,
    input  logic [stp_pkg::TICK_BITS-1:0]   i_counter_max,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_result_kind,
    output logic [2:0]                      o_result_table,
    output logic [stp_pkg::ACTION_BITS-1:0] o_fired_action,
    output logic [2:0]                      o_status_code,
    output logic [1:0]                      o_table_status,
    output logic                            o_last_result
);

    localparam int TB = stp_pkg::TICK_BITS;
    localparam int AB = stp_pkg::ACTION_BITS;
    localparam int TW = stp_pkg::TBL_W;
    localparam int CW = stp_pkg::CNT_W;
    localparam int RW = stp_pkg::RES_W;

    stp_pkg::t_bk_state r_state, n_state;
    stp_pkg::t_req      r_req;
    logic [TB-1:0]      r_tick, n_tick;

    stp_pkg::t_run      r_rs  [stp_pkg::TABLES], n_rs  [stp_pkg::TABLES];
    logic [TB-1:0]      r_exp [stp_pkg::TABLES], n_exp [stp_pkg::TABLES];
    logic [CW-1:0]      r_cp  [stp_pkg::TABLES], n_cp  [stp_pkg::TABLES];
    logic [TW-1:0]      r_lnk [stp_pkg::TABLES], n_lnk [stp_pkg::TABLES];
    logic               r_lv  [stp_pkg::TABLES], n_lv  [stp_pkg::TABLES];
    logic [CW-1:0]      r_tp  [stp_pkg::TABLES];
    logic [TB-1:0]      r_dur [stp_pkg::TABLES];
    logic               r_rep [stp_pkg::TABLES];

    logic [TB-1:0]      mem_off [stp_pkg::MEM_D];
    logic [AB-1:0]      mem_act [stp_pkg::MEM_D];
    logic [stp_pkg::ADDR_W-1:0] rd_a, rd_b, mem_wa;
    logic               mem_we, tbl_we;
    logic [TB-1:0]      r_rda_off, r_rdb_off;
    logic [AB-1:0]      r_rda_act;

    logic [TW-1:0]      r_i, n_i;
    logic [RW-1:0]      r_k, n_k;
    logic               r_pv, n_pv;
    logic [TW-1:0]      r_p_tbl, n_p_tbl;
    logic [AB-1:0]      r_p_act, n_p_act;
    stp_pkg::t_run      r_p_ts, n_p_ts;

    logic [TW-1:0]      r_mt, n_mt;
    logic               r_ret_scan, n_ret_scan;
    logic               m_need;
    logic [stp_pkg::DIV_W-1:0] m_sum;
    logic [TW-1:0]      m_tbl;
    logic               mod_done;
    logic [TB:0]        mod_rem;

    logic               r_out_v, n_out_v;
    logic               r_out_kind, n_out_kind;
    logic [2:0]         r_out_tbl, n_out_tbl;
    logic [AB-1:0]      r_out_act, n_out_act;
    stp_pkg::t_code     r_out_code, n_out_code;
    stp_pkg::t_run      r_out_ts, n_out_ts;
    logic               r_out_last, n_out_last;

    logic               out_free, scan_hit, last_i, fire, need_emit;
    logic               apply_go, req_go, fin_go;
    logic [CW-1:0]      cur_np, cur_cp;

    assign out_free  = !r_out_v || !i_stall;
    assign cur_np    = stp_pkg::eff_points(r_tp[r_i]);
    assign cur_cp    = r_cp[r_i];
    assign scan_hit  = (r_rs[r_i] == stp_pkg::ST_RUN) && (r_exp[r_i] == r_tick);
    assign last_i    = (r_i == TW'(stp_pkg::TABLES - 1));
    assign fire      = cur_cp < cur_np;
    assign need_emit = fire && (r_k < RW'(stp_pkg::MAX_RES));
    assign apply_go  = (r_state == stp_pkg::BK_APPLY) && !(need_emit && r_pv && !out_free);
    assign req_go    = (r_state == stp_pkg::BK_REQ_EX) && out_free;
    assign fin_go    = (r_state == stp_pkg::BK_FIN) && (!r_pv || out_free);
    assign o_req_pop = (r_state == stp_pkg::BK_IDLE) && i_req_valid;

    // Read addresses: point 0 of the addressed table for a request; for a
    // scanned table, its current point and the point that the step needs next.
    always_comb begin
        if (r_state == stp_pkg::BK_REQ_RD || r_state == stp_pkg::BK_REQ_EX) begin
            rd_a = {r_req.tid[TW-1:0], stp_pkg::PT_W'(0)};
            rd_b = rd_a;
        end else begin
            rd_a = {r_i, cur_cp[stp_pkg::PT_W-1:0]};
            if (cur_cp + CW'(1) < cur_np) rd_b = {r_i, stp_pkg::PT_W'(cur_cp + CW'(1))};
            else if (r_lv[r_i]) rd_b = {r_lnk[r_i], stp_pkg::PT_W'(0)};
            else rd_b = {r_i, stp_pkg::PT_W'(0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_off[mem_wa] <= r_req.val;
            mem_act[mem_wa] <= r_req.pact;
        end
        r_rda_off <= mem_off[rd_a];
        r_rda_act <= mem_act[rd_a];
        r_rdb_off <= mem_off[rd_b];
    end

    stp_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (m_need && (req_go || apply_go)),
        .i_dividend (m_sum),
        .i_modulus  ({1'b0, i_counter_max} + (TB+1)'(1)),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            stp_pkg::BK_IDLE: begin
                if (i_req_valid) begin
                    n_state = (i_req.kind == stp_pkg::RQ_TICK) ? stp_pkg::BK_TICK
                                                               : stp_pkg::BK_REQ_RD;
                end
            end
            stp_pkg::BK_REQ_RD: n_state = stp_pkg::BK_REQ_EX;
            stp_pkg::BK_REQ_EX: begin
                if (req_go) n_state = m_need ? stp_pkg::BK_MOD : stp_pkg::BK_IDLE;
            end
            stp_pkg::BK_TICK: n_state = stp_pkg::BK_SCAN;
            stp_pkg::BK_SCAN: begin
                if (scan_hit) n_state = stp_pkg::BK_APPLY;
                else if (last_i) n_state = stp_pkg::BK_FIN;
            end
            stp_pkg::BK_APPLY: begin
                if (apply_go) begin
                    if (m_need) n_state = stp_pkg::BK_MOD;
                    else n_state = last_i ? stp_pkg::BK_FIN : stp_pkg::BK_SCAN;
                end
            end
            stp_pkg::BK_MOD: begin
                if (mod_done) begin
                    if (!r_ret_scan) n_state = stp_pkg::BK_IDLE;
                    else n_state = last_i ? stp_pkg::BK_FIN : stp_pkg::BK_SCAN;
                end
            end
            stp_pkg::BK_FIN: begin
                if (fin_go) n_state = stp_pkg::BK_IDLE;
            end
            default: n_state = stp_pkg::BK_IDLE;
        endcase
    end

    // Datapath and result outputs.
    always_comb begin
        logic [TB-1:0]   fin, dlt, init;
        logic            at_end, stepped;
        logic [TW-1:0]   t, nt;
        stp_pkg::t_code  code;

        n_tick = r_tick;  n_rs = r_rs;  n_exp = r_exp;  n_cp = r_cp;
        n_lnk = r_lnk;    n_lv = r_lv;  n_i = r_i;      n_k = r_k;
        n_pv = r_pv;      n_p_tbl = r_p_tbl; n_p_act = r_p_act; n_p_ts = r_p_ts;
        n_mt = r_mt;      n_ret_scan = r_ret_scan;
        m_need = 1'b0;    m_sum = '0;   m_tbl = '0;
        mem_we = 1'b0;    mem_wa = {r_req.tid[TW-1:0], r_req.pidx[stp_pkg::PT_W-1:0]};
        tbl_we = 1'b0;
        n_out_v = r_out_v && i_stall;
        n_out_kind = r_out_kind; n_out_tbl = r_out_tbl; n_out_act = r_out_act;
        n_out_code = r_out_code; n_out_ts = r_out_ts;   n_out_last = r_out_last;
        fin = '0; dlt = '0; at_end = 1'b0; stepped = 1'b0; code = stp_pkg::SC_OK;
        t = r_req.tid[TW-1:0];
        nt = r_req.oid[TW-1:0];
        init = r_rda_off;

        if (req_go) begin
            if (r_req.kind == stp_pkg::RQ_UNKNOWN) begin
                code = stp_pkg::SC_NO_FUNC;
            end else if (r_req.bad_id) begin
                code = stp_pkg::SC_BAD_ID;
            end else begin
                case (r_req.kind)
                    stp_pkg::RQ_START_REL: begin
                        if (r_req.val == '0 ||
                            ({1'b0, r_req.val} + {1'b0, init}) > {1'b0, i_counter_max})
                            code = stp_pkg::SC_BAD_VALUE;
                        else if (r_rs[t] != stp_pkg::ST_STOP)
                            code = stp_pkg::SC_WRONG_STATE;
                        else begin
                            m_need = 1'b1;
                            m_tbl = t;
                            m_sum = {2'b0, r_tick} + {2'b0, r_req.val} + {2'b0, init};
                            n_cp[t] = '0;
                            n_rs[t] = stp_pkg::ST_RUN;
                        end
                    end
                    stp_pkg::RQ_START_ABS: begin
                        if (r_req.val > i_counter_max) code = stp_pkg::SC_BAD_VALUE;
                        else if (r_rs[t] != stp_pkg::ST_STOP)
                            code = stp_pkg::SC_WRONG_STATE;
                        else begin
                            m_need = 1'b1;
                            m_tbl = t;
                            m_sum = {2'b0, r_req.val} + {2'b0, init};
                            n_cp[t] = '0;
                            n_rs[t] = stp_pkg::ST_RUN;
                        end
                    end
                    stp_pkg::RQ_STOP: begin
                        if (r_rs[t] == stp_pkg::ST_STOP) code = stp_pkg::SC_NO_FUNC;
                        else begin
                            if (r_lv[t]) n_rs[r_lnk[t]] = stp_pkg::ST_STOP;
                            n_lv[t] = 1'b0;
                            if (r_rs[t] == stp_pkg::ST_NEXT) begin
                                for (int j = 0; j < stp_pkg::TABLES; j++) begin
                                    if (r_lv[j] && r_lnk[j] == t) n_lv[j] = 1'b0;
                                end
                            end
                            n_rs[t] = stp_pkg::ST_STOP;
                        end
                    end
                    stp_pkg::RQ_CHAIN: begin
                        if (r_rs[t] != stp_pkg::ST_RUN) code = stp_pkg::SC_NO_FUNC;
                        else if (r_rs[nt] != stp_pkg::ST_STOP)
                            code = stp_pkg::SC_WRONG_STATE;
                        else begin
                            if (r_lv[t]) n_rs[r_lnk[t]] = stp_pkg::ST_STOP;
                            n_lnk[t] = nt;
                            n_lv[t] = 1'b1;
                            n_rs[nt] = stp_pkg::ST_NEXT;
                            n_cp[nt] = '0;
                        end
                    end
                    stp_pkg::RQ_LOAD_PT: begin
                        if (r_req.bad_val) code = stp_pkg::SC_BAD_VALUE;
                        else mem_we = 1'b1;
                    end
                    stp_pkg::RQ_LOAD_TBL: begin
                        if (r_req.bad_val) code = stp_pkg::SC_BAD_VALUE;
                        else tbl_we = 1'b1;
                    end
                    default: code = stp_pkg::SC_NO_FUNC;
                endcase
            end
            n_out_v    = 1'b1;
            n_out_kind = stp_pkg::RK_STATUS;
            n_out_tbl  = r_req.tid;
            n_out_act  = '0;
            n_out_code = code;
            n_out_ts   = r_req.bad_id ? stp_pkg::ST_STOP : n_rs[t];
            n_out_last = 1'b1;
            n_ret_scan = 1'b0;
        end

        if (r_state == stp_pkg::BK_TICK) begin
            n_tick = (r_tick >= i_counter_max) ? '0 : r_tick + TB'(1);
            n_i  = '0;
            n_k  = '0;
            n_pv = 1'b0;
        end

        if (r_state == stp_pkg::BK_SCAN && !scan_hit && !last_i) n_i = r_i + TW'(1);

        if (apply_go) begin
            if (cur_cp + CW'(1) == cur_np) begin
                fin = r_dur[r_i] - r_rda_off;
                if (fin != '0) begin
                    m_need = 1'b1;
                    m_tbl = r_i;
                    m_sum = {2'b0, r_tick} + {2'b0, fin};
                    n_cp[r_i] = cur_cp + CW'(1);
                    stepped = 1'b1;
                end else begin
                    at_end = 1'b1;
                end
            end
            if (!stepped) begin
                if (at_end || !fire) begin
                    if (r_lv[r_i]) begin
                        n_lv[r_i] = 1'b0;
                        n_rs[r_i] = stp_pkg::ST_STOP;
                        n_rs[r_lnk[r_i]] = stp_pkg::ST_RUN;
                        n_cp[r_lnk[r_i]] = '0;
                        m_need = 1'b1;
                        m_tbl = r_lnk[r_i];
                        m_sum = {2'b0, r_tick} + {2'b0, r_rdb_off};
                    end else if (r_rep[r_i]) begin
                        m_need = 1'b1;
                        m_tbl = r_i;
                        m_sum = {2'b0, r_tick} + {2'b0, r_rdb_off};
                    end else begin
                        n_rs[r_i] = stp_pkg::ST_STOP;
                    end
                    n_cp[r_i] = '0;
                end else begin
                    dlt = r_rdb_off - r_rda_off;
                    m_need = 1'b1;
                    m_tbl = r_i;
                    m_sum = {2'b0, r_tick} + {2'b0, dlt};
                    n_cp[r_i] = cur_cp + CW'(1);
                end
            end
            // The newest firing is held back until we know whether it is the last.
            if (need_emit) begin
                if (r_pv) begin
                    n_out_v    = 1'b1;
                    n_out_kind = stp_pkg::RK_FIRED;
                    n_out_tbl  = 3'(r_p_tbl);
                    n_out_act  = r_p_act;
                    n_out_code = stp_pkg::SC_OK;
                    n_out_ts   = r_p_ts;
                    n_out_last = 1'b0;
                end
                n_pv    = 1'b1;
                n_p_tbl = r_i;
                n_p_act = r_rda_act;
                n_p_ts  = n_rs[r_i];
                n_k     = r_k + RW'(1);
            end
            n_ret_scan = 1'b1;
            if (!m_need && !last_i) n_i = r_i + TW'(1);
        end

        if (m_need && (req_go || apply_go)) n_mt = m_tbl;

        if (r_state == stp_pkg::BK_MOD && mod_done) begin
            n_exp[r_mt] = mod_rem[TB-1:0];
            if (r_ret_scan && !last_i) n_i = r_i + TW'(1);
        end

        if (fin_go && r_pv) begin
            n_out_v    = 1'b1;
            n_out_kind = stp_pkg::RK_FIRED;
            n_out_tbl  = 3'(r_p_tbl);
            n_out_act  = r_p_act;
            n_out_code = stp_pkg::SC_OK;
            n_out_ts   = r_p_ts;
            n_out_last = 1'b1;
            n_pv       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stp_pkg::BK_IDLE;
            r_tick  <= '0;
            r_i     <= '0;
            r_k     <= '0;
            r_pv    <= 1'b0;
            r_out_v <= 1'b0;
            r_ret_scan <= 1'b0;
            for (int j = 0; j < stp_pkg::TABLES; j++) begin
                r_rs[j]  <= stp_pkg::ST_STOP;
                r_exp[j] <= '0;
                r_cp[j]  <= '0;
                r_lnk[j] <= '0;
                r_lv[j]  <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
            r_i     <= n_i;
            r_k     <= n_k;
            r_pv    <= n_pv;
            r_out_v <= n_out_v;
            r_ret_scan <= n_ret_scan;
            r_rs  <= n_rs;
            r_exp <= n_exp;
            r_cp  <= n_cp;
            r_lnk <= n_lnk;
            r_lv  <= n_lv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_pop) r_req <= i_req;
        if (tbl_we) begin
            r_tp[r_req.tid[TW-1:0]]  <= r_req.ptot[CW-1:0];
            r_dur[r_req.tid[TW-1:0]] <= r_req.val;
            r_rep[r_req.tid[TW-1:0]] <= r_req.rep;
        end
        r_p_tbl    <= n_p_tbl;
        r_p_act    <= n_p_act;
        r_p_ts     <= n_p_ts;
        r_mt       <= n_mt;
        r_out_kind <= n_out_kind;
        r_out_tbl  <= n_out_tbl;
        r_out_act  <= n_out_act;
        r_out_code <= n_out_code;
        r_out_ts   <= n_out_ts;
        r_out_last <= n_out_last;
    end

    assign o_valid        = r_out_v;
    assign o_result_kind  = r_out_kind;
    assign o_result_table = r_out_tbl;
    assign o_fired_action = r_out_act;
    assign o_status_code  = r_out_code;
    assign o_table_status = r_out_ts;
    assign o_last_result  = r_out_last;

endmodule

FILE: hdl/schedule_table_timer_unit.sv
// Bank of eight schedule tables that share one tick counter.
// Requests enter on the i_valid / o_stall channel; a request is taken at a clock
// edge with i_valid high and o_stall low. Results leave on o_valid / i_stall and
// are taken at an edge with o_valid high and i_stall low. Every non-tick request
// gives exactly one status result; a tick gives one result per firing table, and
// the final result of each request carries o_last_result.
// Requests are decoded into a four-entry queue, so the sender is stalled only
// when that queue is full. A plain request passes from the queue head through a
// read state and an execute state to the output register; a start also waits
// for the bit-serial modulo unit that wraps the expiry time. A tick scans the
// tables one per cycle while none expires, and each expiring table that is
// rescheduled waits for the modulo unit as well. While the receiver stalls, the
// waiting result holds in the output register and the back end pauses at its
// next result; the queue keeps taking requests. The counter limit is written
// via i_cfg_we / i_cfg_data; the user must do so only while idle (unenforced).
// Reset (synchronous, active low) stops all tables, clears the counter, expiry
// times, points and chain links, and sets the limit to its maximum. Point and
// table definitions are not cleared and must be loaded before use.
`include "assert_macros.svh"

module schedule_table_timer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_req_type,
    input  logic [2:0]                        i_table_id,
    input  logic [2:0]                        i_other_table_id,
    input  logic [stp_pkg::TICK_BITS-1:0]     i_value,
    input  logic [3:0]                        i_point_index,
    input  logic [stp_pkg::ACTION_BITS-1:0]   i_point_action,
    input  logic [4:0]                        i_point_total,
    input  logic                              i_repeat_mode,
    input  logic                              i_cfg_we,
    input  logic [stp_pkg::TICK_BITS-1:0]     i_cfg_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_result_kind,
    output logic [2:0]                        o_result_table,
    output logic [stp_pkg::ACTION_BITS-1:0]   o_fired_action,
    output logic [2:0]                        o_status_code,
    output logic [1:0]                        o_table_status,
    output logic                              o_last_result
);

    logic [stp_pkg::TICK_BITS-1:0] r_counter_max;
    logic                          req_valid, req_pop;
    stp_pkg::t_req                 req;

    // The counter limit register; the user must write it only while the block is idle (unchecked).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_counter_max <= '1;
        else if (i_cfg_we) r_counter_max <= i_cfg_data;
    end

    // The front end decodes requests into a short queue.
    stp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_table_id       (i_table_id),
        .i_other_table_id (i_other_table_id),
        .i_value          (i_value),
        .i_point_index    (i_point_index),
        .i_point_action   (i_point_action),
        .i_point_total    (i_point_total),
        .i_repeat_mode    (i_repeat_mode),
        .o_req_valid      (req_valid),
        .i_req_pop        (req_pop),
        .o_req            (req)
    );

    // The back end runs requests and tick scans and owns the output register.
    stp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (req_valid),
        .o_req_pop      (req_pop),
        .i_req          (req),
        .i_counter_max  (r_counter_max),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_result_table (o_result_table),
        .o_fired_action (o_fired_action),
        .o_status_code  (o_status_code),
        .o_table_status (o_table_status),
        .o_last_result  (o_last_result)
    );

    // A status result always closes its request.
    `CHK_SAME(a_status_last, i_clk, i_rst_n, o_valid && !o_result_kind, o_last_result, "status result without last flag")
    // A status result never carries an action word.
    `CHK_SAME(a_status_noact, i_clk, i_rst_n, o_valid && !o_result_kind, o_fired_action == '0, "status result with action")
    // A fired point reports ok, and its table is never left waiting as next.
    `CHK_SAME(a_fired_state, i_clk, i_rst_n, o_valid && o_result_kind, (o_status_code == stp_pkg::SC_OK) && (o_table_status != stp_pkg::ST_NEXT), "bad fired result")
    // The back end never pops an empty queue.
    `CHK_NEVER(a_pop_empty, i_clk, i_rst_n, req_pop && !req_valid, "pop from empty request queue")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // One request as it is offered on the input channel.
    typedef struct {
        stp_pkg::t_req_kind kind;
        logic [2:0]  tid;
        logic [2:0]  oid;
        logic [15:0] val;
        logic [3:0]  pidx;
        logic [15:0] pact;
        logic [4:0]  ptot;
        logic        rep;
    } t_req_item;

    // One result as the block should present it.
    typedef struct {
        logic           kind;
        logic [2:0]     tbl;
        logic [15:0]    act;
        stp_pkg::t_code code;
        stp_pkg::t_run  ts;
        logic           last;
    } t_res_item;

    localparam int CYCLE_LIMIT = 800000;
    // Longest time the block may still be busy on queued ticks that give no result.
    localparam int SETTLE_CYCLES = 2000;
    localparam int LONG_HOLD = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [2:0] i_req_type = '0;
    logic [2:0] i_table_id = '0;
    logic [2:0] i_other_table_id = '0;
    logic [15:0] i_value = '0;
    logic [3:0] i_point_index = '0;
    logic [15:0] i_point_action = '0;
    logic [4:0] i_point_total = '0;
    logic i_repeat_mode = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_result_kind;
    logic [2:0] o_result_table;
    logic [15:0] o_fired_action;
    logic [2:0] o_status_code;
    logic [1:0] o_table_status;
    logic o_last_result;

    schedule_table_timer_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_table_id(i_table_id),
        .i_other_table_id(i_other_table_id), .i_value(i_value),
        .i_point_index(i_point_index), .i_point_action(i_point_action),
        .i_point_total(i_point_total), .i_repeat_mode(i_repeat_mode),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result_kind(o_result_kind), .o_result_table(o_result_table),
        .o_fired_action(o_fired_action), .o_status_code(o_status_code),
        .o_table_status(o_table_status), .o_last_result(o_last_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Requests waiting to be offered, and results the block still owes.
    t_req_item pending_reqs[$];
    t_res_item owed_results[$];

    int errors = 0;
    int reqs_taken = 0;
    int results_seen = 0;
    int fires_seen = 0;
    int cycles = 0;
    bit quiet = 1'b0;       // no idling on either side in the closing part
    int hold_asks = 0;      // bumped by the sequencer to ask for one long receiver hold
    int hold_done = 0;

    // Shadow of the timer bank, updated as each request is taken.
    int unsigned   limit_m;
    int unsigned   tick_now;
    stp_pkg::t_run run_m[stp_pkg::TABLES];
    int unsigned   expiry_m[stp_pkg::TABLES];
    int unsigned   point_m[stp_pkg::TABLES];
    int unsigned   link_m[stp_pkg::TABLES];
    bit            link_ok[stp_pkg::TABLES];
    int unsigned   offs_m[stp_pkg::TABLES][stp_pkg::POINTS];
    logic [15:0]   acts_m[stp_pkg::TABLES][stp_pkg::POINTS];
    int unsigned   npts_m[stp_pkg::TABLES];
    int unsigned   dur_m[stp_pkg::TABLES];
    bit            rep_m[stp_pkg::TABLES];

    // What the stimulus side knows has been written, so that it never makes the
    // block read a point or table definition that was never loaded.
    bit          pt_loaded[stp_pkg::TABLES][stp_pkg::POINTS];
    bit          tbl_loaded[stp_pkg::TABLES];
    int unsigned tbl_npts[stp_pkg::TABLES];

    function automatic int unsigned wrap_add(int unsigned a, int unsigned b);
        return (a + b) % (limit_m + 1);
    endfunction

    function automatic int unsigned used_points(int unsigned t);
        if (npts_m[t] < 1) return 1;
        if (npts_m[t] > stp_pkg::POINTS) return stp_pkg::POINTS;
        return npts_m[t];
    endfunction

    // Removes a table from service, stops the table chained from it, and drops any chain to it.
    function automatic void halt_table(int unsigned t);
        if (link_ok[t]) begin
            run_m[link_m[t]] = stp_pkg::ST_STOP;
            link_ok[t] = 1'b0;
        end
        if (run_m[t] == stp_pkg::ST_NEXT) begin
            for (int i = 0; i < stp_pkg::TABLES; i++)
                if (link_ok[i] && link_m[i] == t) link_ok[i] = 1'b0;
        end
        run_m[t] = stp_pkg::ST_STOP;
    endfunction

    // Moves a table that just expired on to its next point, its final delay,
    // or the end of the round: handover, repeat or stop.
    function automatic void step_table(int unsigned t);
        int unsigned np, cp, fin, d, n;
        bit at_end;
        np = used_points(t);
        cp = point_m[t];
        at_end = 1'b0;
        if (cp + 1 == np) begin
            fin = (dur_m[t] - offs_m[t][np - 1]) & 16'hFFFF;
            if (fin != 0) begin
                expiry_m[t] = wrap_add(tick_now, fin);
                point_m[t] = cp + 1;
                return;
            end
            at_end = 1'b1;
        end
        if (at_end || cp >= np) begin
            if (link_ok[t]) begin
                n = link_m[t];
                link_ok[t] = 1'b0;
                run_m[t] = stp_pkg::ST_STOP;
                run_m[n] = stp_pkg::ST_RUN;
                point_m[n] = 0;
                expiry_m[n] = wrap_add(tick_now, offs_m[n][0]);
            end else if (rep_m[t]) begin
                expiry_m[t] = wrap_add(tick_now, offs_m[t][0]);
            end else begin
                run_m[t] = stp_pkg::ST_STOP;
            end
            point_m[t] = 0;
        end else begin
            d = (offs_m[t][cp + 1] - offs_m[t][cp]) & 16'hFFFF;
            expiry_m[t] = wrap_add(tick_now, d);
            point_m[t] = cp + 1;
        end
    endfunction

    // Applies one taken request to the shadow and queues the results it owes.
    function automatic void run_request(t_req_item r);
        t_res_item e;
        int unsigned t, n, k, cp, first;
        bit fire;
        logic [15:0] act;
        stp_pkg::t_code code;
        t = r.tid;
        code = stp_pkg::SC_OK;
        if (r.kind == stp_pkg::RQ_TICK) begin
            k = 0;
            tick_now = (tick_now >= limit_m) ? 0 : tick_now + 1;
            for (int i = 0; i < stp_pkg::TABLES; i++) begin
                if (run_m[i] == stp_pkg::ST_RUN && expiry_m[i] == tick_now) begin
                    cp = point_m[i];
                    fire = cp < used_points(i);
                    act = fire ? acts_m[i][cp % stp_pkg::POINTS] : 16'h0;
                    step_table(i);
                    if (fire && k < stp_pkg::MAX_RES) begin
                        e = '{stp_pkg::RK_FIRED, 3'(i), act, stp_pkg::SC_OK, run_m[i], 1'b0};
                        owed_results.push_back(e);
                        k++;
                    end
                end
            end
            if (k > 0) begin
                e = owed_results.pop_back();
                e.last = 1'b1;
                owed_results.push_back(e);
            end
            return;
        end
        first = offs_m[t][0];
        case (r.kind)
            stp_pkg::RQ_START_REL: begin
                if (r.val == 0 || r.val + first > limit_m) code = stp_pkg::SC_BAD_VALUE;
                else if (run_m[t] != stp_pkg::ST_STOP) code = stp_pkg::SC_WRONG_STATE;
                else begin
                    expiry_m[t] = wrap_add(tick_now, r.val + first);
                    point_m[t] = 0;
                    run_m[t] = stp_pkg::ST_RUN;
                end
            end
            stp_pkg::RQ_START_ABS: begin
                if (r.val > limit_m) code = stp_pkg::SC_BAD_VALUE;
                else if (run_m[t] != stp_pkg::ST_STOP) code = stp_pkg::SC_WRONG_STATE;
                else begin
                    expiry_m[t] = wrap_add(r.val, first);
                    point_m[t] = 0;
                    run_m[t] = stp_pkg::ST_RUN;
                end
            end
            stp_pkg::RQ_STOP: begin
                if (run_m[t] == stp_pkg::ST_STOP) code = stp_pkg::SC_NO_FUNC;
                else halt_table(t);
            end
            stp_pkg::RQ_CHAIN: begin
                n = r.oid;
                if (run_m[t] != stp_pkg::ST_RUN) code = stp_pkg::SC_NO_FUNC;
                else if (run_m[n] != stp_pkg::ST_STOP) code = stp_pkg::SC_WRONG_STATE;
                else begin
                    if (link_ok[t]) run_m[link_m[t]] = stp_pkg::ST_STOP;
                    link_m[t] = n;
                    link_ok[t] = 1'b1;
                    run_m[n] = stp_pkg::ST_NEXT;
                    point_m[n] = 0;
                end
            end
            stp_pkg::RQ_LOAD_PT: begin
                offs_m[t][r.pidx] = r.val;
                acts_m[t][r.pidx] = r.pact;
            end
            stp_pkg::RQ_LOAD_TBL: begin
                if (r.ptot < 1 || r.ptot > stp_pkg::POINTS) code = stp_pkg::SC_BAD_VALUE;
                else begin
                    npts_m[t] = r.ptot;
                    dur_m[t] = r.val;
                    rep_m[t] = r.rep;
                end
            end
            default: code = stp_pkg::SC_NO_FUNC;
        endcase
        e = '{stp_pkg::RK_STATUS, r.tid, 16'h0, code, run_m[t], 1'b1};
        owed_results.push_back(e);
    endfunction

    function automatic int unsigned loaded_prefix(int unsigned t);
        int unsigned c;
        c = 0;
        while (c < stp_pkg::POINTS && pt_loaded[t][c]) c++;
        return c;
    endfunction

    function automatic bit is_defined(int unsigned t);
        return tbl_loaded[t] && loaded_prefix(t) >= tbl_npts[t];
    endfunction

    // Builds a request and notes any definition it loads.
    function automatic t_req_item make_req(stp_pkg::t_req_kind kind, int tid, int oid,
                                           int val, int pidx, int pact, int ptot,
                                           int rep);
        t_req_item r;
        r = '{kind, 3'(tid), 3'(oid), 16'(val), 4'(pidx), 16'(pact), 5'(ptot), 1'(rep)};
        if (kind == stp_pkg::RQ_LOAD_PT) pt_loaded[tid][pidx] = 1'b1;
        if (kind == stp_pkg::RQ_LOAD_TBL && ptot >= 1 && ptot <= stp_pkg::POINTS) begin
            tbl_loaded[tid] = 1'b1;
            tbl_npts[tid] = ptot;
        end
        return r;
    endfunction

    // Mostly a small value, now and then any 16-bit value.
    function automatic int small_or_any(int hi);
        return ($urandom_range(0, 99) < 85) ? $urandom_range(0, hi) : $urandom_range(0, 65535);
    endfunction

    // One random request. Starts only name fully loaded tables and chains only hand
    // over to one; table loads mostly claim no more points than have been loaded in order.
    function automatic t_req_item random_req(int unsigned lim);
        int unsigned defs[$];
        int unsigned r, t, d, pc;
        int val, pidx, ptot;
        stp_pkg::t_req_kind kind;
        for (int i = 0; i < stp_pkg::TABLES; i++) if (is_defined(i)) defs.push_back(i);
        r = $urandom_range(0, 99);
        t = $urandom_range(0, stp_pkg::TABLES - 1);
        d = (defs.size() > 0) ? defs[$urandom_range(0, defs.size() - 1)] : 0;
        if (defs.size() == 0 && r >= 36 && r < 68) r = 70;
        if (r < 36) begin
            return make_req(stp_pkg::RQ_TICK, t, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom);
        end else if (r < 52) begin
            kind = ($urandom_range(0, 1) == 0) ? stp_pkg::RQ_START_REL
                                               : stp_pkg::RQ_START_ABS;
            if (kind == stp_pkg::RQ_START_REL) begin
                val = $urandom_range(0, 9) == 0 ? 0 : small_or_any(20);
                if (val == 0 && $urandom_range(0, 1) == 1) val = $urandom_range(1, 5);
            end else begin
                val = ($urandom_range(0, 99) < 80) ? $urandom_range(0, lim) :
                      $urandom_range(0, 65535);
            end
            return make_req(kind, d, $urandom, val, $urandom, $urandom, $urandom, $urandom);
        end else if (r < 60) begin
            return make_req(stp_pkg::RQ_STOP, ($urandom_range(0, 1) == 0) ? d : t, $urandom,
                            $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (r < 68) begin
            return make_req(stp_pkg::RQ_CHAIN, ($urandom_range(0, 9) < 7) ?
                            defs[$urandom_range(0, defs.size() - 1)] : t, d,
                            $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (r < 85) begin
            pc = loaded_prefix(t);
            pidx = (pc < stp_pkg::POINTS && $urandom_range(0, 9) < 7) ? pc
                                                                    : $urandom_range(0, 15);
            return make_req(stp_pkg::RQ_LOAD_PT, t, $urandom, small_or_any(40), pidx,
                            $urandom_range(0, 65535), $urandom, $urandom);
        end else if (r < 98) begin
            pc = loaded_prefix(t);
            if (pc == 0) ptot = $urandom_range(0, 31);
            else if ($urandom_range(0, 99) < 85) ptot = $urandom_range(1, pc);
            else ptot = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
            return make_req(stp_pkg::RQ_LOAD_TBL, t, $urandom, small_or_any(60), $urandom,
                            $urandom, ptot, $urandom_range(0, 1));
        end
        return make_req(stp_pkg::RQ_UNKNOWN, t, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("mismatch at cycle %0d: %s expected %0d got %0d", cycles, what, want, got);
        errors++;
    endtask

    // Driver: offers requests from the pending queue, with random gaps.
    int send_gap = 0;
    t_req_item on_wire;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                run_request(on_wire);
                reqs_taken++;
            end
            if (i_valid && o_stall) begin
                // A stalled request stays on the wire unchanged.
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 6) - 1;
                i_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                on_wire = pending_reqs.pop_front();
                i_valid <= 1'b1;
                i_req_type <= on_wire.kind;
                i_table_id <= on_wire.tid;
                i_other_table_id <= on_wire.oid;
                i_value <= on_wire.val;
                i_point_index <= on_wire.pidx;
                i_point_action <= on_wire.pact;
                i_point_total <= on_wire.ptot;
                i_repeat_mode <= on_wire.rep;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each taken result against the oldest one owed, and
    // drives the receiver stall in random bursts or one long hold.
    int stall_gap = 0;
    int hold_left = 0;
    t_res_item want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (o_result_kind == stp_pkg::RK_FIRED) fires_seen++;
                if (owed_results.size() == 0) begin
                    report_mismatch("unexpected result, table", -1, o_result_table);
                end else begin
                    want = owed_results.pop_front();
                    if (o_result_kind !== want.kind)
                        report_mismatch("result_kind", want.kind, o_result_kind);
                    if (o_result_table !== want.tbl)
                        report_mismatch("result_table", want.tbl, o_result_table);
                    if (o_fired_action !== want.act)
                        report_mismatch("fired_action", want.act, o_fired_action);
                    if (o_status_code !== want.code)
                        report_mismatch("status_code", want.code, o_status_code);
                    if (o_table_status !== want.ts)
                        report_mismatch("table_status", want.ts, o_table_status);
                    if (o_last_result !== want.last)
                        report_mismatch("last_result", want.last, o_last_result);
                end
            end
            if (hold_done != hold_asks) begin
                hold_done = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else if (stall_gap > 0) begin
                stall_gap--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                stall_gap = $urandom_range(1, 6) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycles, owed_results.size());
            $display("FAIL schedule_table_timer_unit");
            $finish;
        end
    end

    // Waits until every request is taken and every result has come back, then
    // lets the block settle before the limit register may be touched.
    task automatic drain;
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || owed_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(int unsigned v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= 16'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_m = v;
    endtask

    int unsigned phase_limits[5] = '{1, 29, 65535, 300, 12};

    initial begin
        limit_m = 65535;
        tick_now = 0;
        for (int i = 0; i < stp_pkg::TABLES; i++) begin
            run_m[i] = stp_pkg::ST_STOP;
            expiry_m[i] = 0;
            point_m[i] = 0;
            link_m[i] = 0;
            link_ok[i] = 1'b0;
            npts_m[i] = 0;
            dur_m[i] = 0;
            rep_m[i] = 1'b0;
            tbl_loaded[i] = 1'b0;
            tbl_npts[i] = 0;
            for (int p = 0; p < stp_pkg::POINTS; p++) begin
                offs_m[i][p] = 0;
                acts_m[i][p] = '0;
                pt_loaded[i][p] = 1'b0;
            end
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_limit(65535);

        // Directed opening: extremes of the fields, each request kind, bad
        // values, wrong states, a zero final delay, chaining and handover.
        pending_reqs.push_back(make_req(stp_pkg::RQ_LOAD_PT, 0, 7, 2, 0, 16'hFFFF, 31, 1));
        pending_reqs.push_back(make_req(stp_pkg::RQ_LOAD_PT, 0, 0, 5, 1, 0, 0, 0));
        pending_reqs.push_back(make_req(stp_pkg::RQ_LOAD_PT, 7, 0, 65535, 15, 16'h1234, 0, 0));
        pending_reqs.push_back(make_req(stp_pkg::RQ_LOAD_TBL, 0, 0, 9, 0, 0, 2, 1));
        pending_reqs.push_back(make_req(stp_pkg::RQ_LOAD_PT, 1, 0, 0, 0, 16'h00AA, 0, 0));
        pending_reqs.push_back(make_req(stp_pkg::RQ_LOAD_TBL, 1, 0, 0, 0, 0, 1, 0));
        pending_reqs.push_back(make_req(stp_pkg::RQ_LOAD_TBL, 2, 0, 7, 0, 0, 0, 1));
        pending_reqs.push_back(make_req(stp_pkg::RQ_LOAD_TBL, 2, 0, 7, 0, 0, 31, 1));
        pending_reqs.push_back(make_req(stp_pkg::RQ_START_REL, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(stp_pkg::RQ_START_REL, 0, 0, 65535, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(stp_pkg::RQ_START_ABS, 0, 0, 3, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(stp_pkg::RQ_START_REL, 0, 0, 4, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(stp_pkg::RQ_CHAIN, 1, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(stp_pkg::RQ_CHAIN, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(stp_pkg::RQ_CHAIN, 0, 1, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(stp_pkg::RQ_UNKNOWN, 7, 7, 65535, 15, 65535, 31, 1));
        for (int i = 0; i < 10; i++)
            pending_reqs.push_back(make_req(stp_pkg::RQ_TICK, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(stp_pkg::RQ_STOP, 1, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(stp_pkg::RQ_STOP, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(stp_pkg::RQ_STOP, 0, 0, 0, 0, 0, 0, 0));
        // Sender pauses here until the block owes nothing.
        drain();

        // Random phases, each under its own counter limit, the extremes among them.
        // The second phase opens with a long receiver hold so the request queue
        // fills up and the input stalls; the last phase runs without idling.
        for (int ph = 0; ph < 5; ph++) begin
            write_limit(phase_limits[ph]);
            if (ph == 1) hold_asks++;
            if (ph == 4) quiet = 1'b1;
            for (int i = 0; i < ((ph == 4) ? 70 : 60); i++)
                pending_reqs.push_back(random_req(phase_limits[ph]));
            drain();
        end

        foreach (owed_results[i])
            report_mismatch("result never came, table", owed_results[i].tbl, -1);
        $display("covered %0d requests under five counter limits, %0d results checked",
                 reqs_taken, results_seen);
        $display("of which %0d fired expiry points, %0d mismatches", fires_seen, errors);
        if (errors == 0) begin
            $display("PASS schedule_table_timer_unit");
        end else begin
            $display("FAIL schedule_table_timer_unit");
        end
        $finish;
    end

endmodule
